@@ design/nat_pkg.sv @@
`timescale 1ns / 1ps
package nat_pkg;
    localparam int ConnEntriesDefault = 64;
    localparam int RuleEntriesDefault = 8;
    localparam logic [15:0] PortLimit = 16'hffff;

    typedef enum logic [1:0] {
        REQ_OUT  = 2'd0,
        REQ_IN   = 2'd1,
        REQ_LOAD = 2'd2,
        REQ_BAD  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_NEW    = 3'd1,
        ST_NORULE = 3'd2,
        ST_FULL   = 3'd3,
        ST_NOPORT = 3'd4,
        ST_LOADED = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [2:0]  rule_slot;
        logic [31:0] rule_public_ip;
        logic [15:0] rule_public_port;
        logic [31:0] rule_private_ip;
        logic [15:0] rule_private_port;
        logic        rule_enable;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_src_ip;
        logic [15:0] out_src_port;
        logic [31:0] out_dst_ip;
        logic [15:0] out_dst_port;
    } t_out;

    // classified work item handed from front to back
    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] rip;    // remote ip (key)
        logic [15:0] rport;
        logic [31:0] kip;    // private ip (outbound) or public ip (inbound)
        logic [15:0] kport;
        t_in         raw;
    } t_work;

    // connection entry as stored in ram
    typedef struct packed {
        logic [31:0] remote_ip;
        logic [15:0] remote_port;
        logic [31:0] private_ip;
        logic [15:0] private_port;
        logic [31:0] public_ip;
        logic [15:0] public_port;
    } t_conn;
endpackage

@@ design/nat_ram.sv @@
`timescale 1ns / 1ps
module nat_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/nat_front.sv @@
`timescale 1ns / 1ps
module nat_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  nat_pkg::t_in  i_item,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output nat_pkg::t_work o_q_item
);
    import nat_pkg::*;

    // two-entry queue
    t_work r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;
    t_work w_cls;

    // pick search key by direction
    always_comb begin
        w_cls.req = i_item.req_type;
        w_cls.raw = i_item;
        if (i_item.req_type == REQ_IN) begin
            w_cls.rip   = i_item.src_ip;
            w_cls.rport = i_item.src_port;
            w_cls.kip   = i_item.dst_ip;
            w_cls.kport = i_item.dst_port;
        end else begin
            w_cls.rip   = i_item.dst_ip;
            w_cls.rport = i_item.dst_port;
            w_cls.kip   = i_item.src_ip;
            w_cls.kport = i_item.src_port;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_q[r_wp] <= w_cls;
                r_wp      <= ~r_wp;
            end
            if (o_q_valid && i_q_ready) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_valid && o_ready} - {1'b0, o_q_valid && i_q_ready};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("full queue ready");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !o_q_valid) else $error("empty queue valid");
endmodule

@@ design/nat_back.sv @@
`timescale 1ns / 1ps
module nat_back #(
    parameter int ConnEntries = nat_pkg::ConnEntriesDefault,
    parameter int RuleEntries = nat_pkg::RuleEntriesDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_ext_ip,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  nat_pkg::t_work i_q_item,
    output logic           o_valid,
    input  logic           i_ready,
    output nat_pkg::t_out  o_item
);
    import nat_pkg::*;

    localparam int CW = $clog2(ConnEntries);
    localparam int NW = $clog2(ConnEntries + 1);
    localparam int RW = (RuleEntries > 1) ? $clog2(RuleEntries) : 1;
    localparam int RCW = $clog2(RuleEntries + 1);

    typedef enum logic [2:0] {S_IDLE, S_CONN, S_CWAIT, S_RULE, S_DONE, S_OUT} t_state;

    t_state r_state;
    t_work  r_w;
    logic [NW-1:0] r_count, r_idx;
    logic [15:0]   r_next_port;
    logic [RCW-1:0] r_ridx;
    logic          r_found;
    logic [31:0]   r_nip;
    logic [15:0]   r_nport;
    t_out          r_out;

    logic [31:0] r_rpub_ip   [RuleEntries];
    logic [15:0] r_rpub_port [RuleEntries];
    logic [31:0] r_rpri_ip   [RuleEntries];
    logic [15:0] r_rpri_port [RuleEntries];
    logic [RuleEntries-1:0] r_ract;

    logic  w_we;
    t_conn w_wdata, w_rdata;
    logic  w_hit;
    logic [RW-1:0] w_ri;
    logic [RW-1:0] w_slot;

    assign w_ri   = r_ridx[RW-1:0];
    assign w_slot = RW'(i_q_item.raw.rule_slot);

    nat_ram #(.Width($bits(t_conn)), .Depth(ConnEntries)) u_conn (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[CW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(r_idx[CW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        if (r_w.req == REQ_IN) begin
            w_hit = (w_rdata.remote_ip == r_w.rip) && (w_rdata.remote_port == r_w.rport)
                 && (w_rdata.public_ip == r_w.kip) && (w_rdata.public_port == r_w.kport);
        end else begin
            w_hit = (w_rdata.remote_ip == r_w.rip) && (w_rdata.remote_port == r_w.rport)
                 && (w_rdata.private_ip == r_w.kip)
                 && (w_rdata.private_port == r_w.kport);
        end
    end

    // append on a successful miss
    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        if (r_state == S_DONE && r_count != NW'(ConnEntries)) begin
            if (r_w.req == REQ_OUT && r_next_port != PortLimit) begin
                w_we    = 1'b1;
                w_wdata = '{r_w.rip, r_w.rport, r_w.kip, r_w.kport, i_ext_ip, r_next_port};
            end else if (r_w.req == REQ_IN && r_found) begin
                w_we    = 1'b1;
                w_wdata = '{r_w.rip, r_w.rport, r_nip, r_nport, r_w.kip, r_w.kport};
            end
        end
    end

    assign o_q_ready = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_item    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_port <= 16'd1;
            r_ract      <= '0;
            r_idx       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_w     <= i_q_item;
                        r_idx   <= '0;
                        r_ridx  <= '0;
                        r_found <= 1'b0;
                        r_nip   <= '0;
                        r_nport <= '0;
                        r_out   <= '{ST_NORULE, 32'd0, 16'd0, 32'd0, 16'd0};
                        if (i_q_item.req == REQ_LOAD) begin
                            if ({29'd0, i_q_item.raw.rule_slot} < 32'(RuleEntries)) begin
                                r_rpub_ip[w_slot]   <= i_q_item.raw.rule_public_ip;
                                r_rpub_port[w_slot] <= i_q_item.raw.rule_public_port;
                                r_rpri_ip[w_slot]   <= i_q_item.raw.rule_private_ip;
                                r_rpri_port[w_slot] <= i_q_item.raw.rule_private_port;
                                r_ract[w_slot]      <= i_q_item.raw.rule_enable;
                            end
                            r_out.status <= ST_LOADED;
                            r_state      <= S_OUT;
                        end else if (i_q_item.req == REQ_BAD) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_CONN;
                        end
                    end
                end
                S_CONN: begin
                    // ram address r_idx is issued; data valid next cycle
                    if (r_idx == r_count) begin
                        r_state <= (r_w.req == REQ_IN) ? S_RULE : S_DONE;
                    end else begin
                        r_state <= S_CWAIT;
                    end
                end
                S_CWAIT: begin
                    if (w_hit) begin
                        if (r_w.req == REQ_IN) begin
                            r_out <= '{ST_HIT, r_w.rip, r_w.rport,
                                       w_rdata.private_ip, w_rdata.private_port};
                        end else begin
                            r_out <= '{ST_HIT, w_rdata.public_ip, w_rdata.public_port,
                                       r_w.rip, r_w.rport};
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= r_idx + NW'(1);
                        r_state <= S_CONN;
                    end
                end
                S_RULE: begin
                    if (r_ridx == RCW'(RuleEntries)) begin
                        r_state <= S_DONE;
                    end else begin
                        // last match wins
                        if (r_ract[w_ri] && r_rpub_ip[w_ri] == r_w.kip
                                && r_rpub_port[w_ri] == r_w.kport) begin
                            r_found <= 1'b1;
                            r_nip   <= r_rpri_ip[w_ri];
                            r_nport <= r_rpri_port[w_ri];
                        end
                        r_ridx <= r_ridx + RCW'(1);
                    end
                end
                S_DONE: begin
                    if (r_w.req == REQ_OUT) begin
                        if (r_next_port == PortLimit) begin
                            r_out.status <= ST_NOPORT;
                        end else if (r_count == NW'(ConnEntries)) begin
                            r_out.status <= ST_FULL;
                        end else begin
                            r_out       <= '{ST_NEW, i_ext_ip, r_next_port,
                                             r_w.rip, r_w.rport};
                            r_next_port <= r_next_port + 16'd1;
                        end
                    end else begin
                        if (!r_found) begin
                            r_out.status <= ST_NORULE;
                        end else if (r_count == NW'(ConnEntries)) begin
                            r_out.status <= ST_FULL;
                        end else begin
                            r_out <= '{ST_NEW, r_w.rip, r_w.rport, r_nip, r_nport};
                        end
                    end
                    if (w_we) begin
                        r_count <= r_count + NW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(ConnEntries)) else $error("connection count overflow");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count) else $error("search index past count");
    a_we_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_count < NW'(ConnEntries)) else $error("append into full table");
    a_port_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_port != 16'd0) else $error("port counter wrapped");
endmodule

@@ design/nat_port_translation_table.sv @@
`timescale 1ns / 1ps
// channel   signals                             direction
// request   i_valid / o_ready / i_req           in
// result    o_valid / i_ready / o_rsp           out
// config    i_cfg_we / i_cfg_wdata              in, external ip
//
// a packet's time from request transfer to result transfer grows with the n
// connection entries live, and an inbound miss also walks all RULE_ENTRIES rules;
// the single read port of the connection ram, read one entry at a time, sets this
// reset clears counts and rule valid marks
// a two-entry queue lets requests enter while the back end searches or stalls
module nat_port_translation_table #(
    parameter int CONN_ENTRIES = nat_pkg::ConnEntriesDefault,
    parameter int RULE_ENTRIES = nat_pkg::RuleEntriesDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  nat_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output nat_pkg::t_out o_rsp,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata
);
    import nat_pkg::*;

    logic [31:0] r_ext_ip;
    logic  w_qv, w_qr;
    t_work w_qi;

    // external ip register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_ip <= '0;
        end else if (i_cfg_we) begin
            r_ext_ip <= i_cfg_wdata;
        end
    end

    nat_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_req),
        .o_q_valid(w_qv),
        .i_q_ready(w_qr),
        .o_q_item (w_qi)
    );

    nat_back #(.ConnEntries(CONN_ENTRIES), .RuleEntries(RULE_ENTRIES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ext_ip (r_ext_ip),
        .i_q_valid(w_qv),
        .o_q_ready(w_qr),
        .i_q_item (w_qi),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_item   (o_rsp)
    );
endmodule
